// File: rtl/rgb2yuv_pkg.sv
// Shared constants, types and helper functions for the RGB to YUV 4:2:0 converter.
// Depends on nothing; used by rgb2yuv_csc and rgb_to_yuv420_converter.
`default_nettype none

package rgb2yuv_pkg;

    // line geometry
    localparam int MAX_WIDTH   = 2048;
    localparam int STORE_DEPTH = MAX_WIDTH / 2;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int LEN_W       = COL_W + 1;
    localparam int CFG_W       = 12;
    localparam int RESET_WIDTH = 640;

    // sample widths
    localparam int PIX_W  = 8;
    localparam int PAIR_W = PIX_W + 1;
    localparam int QUAD_W = PIX_W + 2;
    localparam int ENTRY_W = 2 * PAIR_W;
    localparam int PROD_W = 24;
    localparam int FRAC_W = 16;

    // Q16 coefficients
    localparam logic [15:0] COEF_YR = 16'd19595;
    localparam logic [15:0] COEF_YG = 16'd38470;
    localparam logic [15:0] COEF_YB = 16'd7471;
    localparam logic [15:0] COEF_UR = 16'd11036;
    localparam logic [15:0] COEF_UG = 16'd21732;
    localparam logic [15:0] COEF_VG = 16'd27440;
    localparam logic [15:0] COEF_VB = 16'd5328;
    localparam logic [7:0]  CHROMA_OFFSET = 8'd128;

    // clamp limits
    localparam logic [7:0] LUMA_MIN   = 8'd16;
    localparam logic [7:0] LUMA_MAX   = 8'd235;
    localparam logic [7:0] CHROMA_MIN = 8'd16;
    localparam logic [7:0] CHROMA_MAX = 8'd240;

    typedef logic [PIX_W-1:0]   pix_t;
    typedef logic [COL_W-1:0]   col_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [LEN_W-1:0]   len_t;
    typedef logic [ENTRY_W-1:0] entry_t;

    // saturate a byte to a range
    function automatic pix_t clamp_byte(input pix_t x, input pix_t lo, input pix_t hi);
        pix_t r;
        r = x;
        if (x < lo)
        begin
            r = lo;
        end
        else if (x > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    // usable line length: even, at least two, at most the maximum width
    function automatic len_t line_len(input logic [CFG_W-1:0] fw);
        logic [31:0] w;
        w = {20'd0, fw[CFG_W-1:1], 1'b0};
        if (w < 32'd2)
        begin
            w = 32'd2;
        end
        else if (w > 32'(MAX_WIDTH))
        begin
            w = 32'(MAX_WIDTH);
        end
        return w[LEN_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/rgb_to_yuv420_converter.sv
// RGB to YUV 4:2:0 converter: luma every pixel, averaged chroma per 2x2 block.
// An accepted input beat passes the input stage register, then the output register.
// Throughput: one pixel per cycle unless the output stalls; the line store has one write and one read port.
// Reset clears handshake state, pixel position, held chroma and frame_width (640).
// The line store is not cleared; no clearing pass is run.
// Depends on rgb2yuv_pkg and rgb2yuv_csc.
`default_nettype none

module rgb_to_yuv420_converter
(
    input  wire        clk,
    input  wire        rst_n,
    // configuration
    input  wire        cfg_wr_en,
    input  wire [11:0] cfg_wr_data,      // frame_width
    // pixel input
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [23:0] s_axis_tdata,     // blue[7:0], green[15:8], red[23:16]
    input  wire        s_axis_tuser,     // frame_start
    // result output
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [23:0] m_axis_tdata,    // luma[7:0], cb[15:8], cr[23:16]
    output logic       m_axis_tuser      // chroma_valid
);

    localparam int PW  = rgb2yuv_pkg::PIX_W;
    localparam int QW  = rgb2yuv_pkg::QUAD_W;
    localparam int PRW = rgb2yuv_pkg::PAIR_W;
    localparam int CW  = rgb2yuv_pkg::COL_W;
    localparam int LW  = rgb2yuv_pkg::LEN_W;

    // configuration register
    logic [rgb2yuv_pkg::CFG_W-1:0] frame_width_reg;

    // position state
    rgb2yuv_pkg::col_t column_reg, column_next;
    logic              odd_row_reg, odd_row_next;
    rgb2yuv_pkg::col_t cur_col;
    logic              cur_row;
    rgb2yuv_pkg::len_t len;
    logic [LW-1:0]     col_inc;

    // input stage
    logic              s1_valid_reg;
    rgb2yuv_pkg::pix_t s1_blue_reg, s1_green_reg, s1_red_reg;
    logic              s1_col_odd_reg, s1_row_odd_reg;
    rgb2yuv_pkg::idx_t s1_idx_reg;

    // handshake
    logic s_accept, out_free, s1_adv;

    // chroma pairing
    rgb2yuv_pkg::pix_t   held_u_reg, held_v_reg;
    rgb2yuv_pkg::entry_t store_mem [rgb2yuv_pkg::STORE_DEPTH];
    rgb2yuv_pkg::entry_t rd_data_reg;

    // datapath
    rgb2yuv_pkg::pix_t luma, u_raw, v_raw;
    logic [PRW-1:0]    pair_u, pair_v;
    logic [QW-1:0]     quad_u, quad_v;
    logic              chroma_hit;
    rgb2yuv_pkg::pix_t cb, cr;

    // handshake: the output register frees the input stage
    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign s1_adv        = s1_valid_reg && out_free;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= rgb2yuv_pkg::CFG_W'(rgb2yuv_pkg::RESET_WIDTH);
        end
        else if (cfg_wr_en)
        begin
            frame_width_reg <= cfg_wr_data;
        end
    end

    // pixel position for the beat being accepted
    always_comb
    begin
        len          = rgb2yuv_pkg::line_len(frame_width_reg);
        cur_col      = s_axis_tuser ? '0 : column_reg;
        cur_row      = s_axis_tuser ? 1'b0 : odd_row_reg;
        col_inc      = LW'(cur_col) + LW'(1);
        column_next  = column_reg;
        odd_row_next = odd_row_reg;
        if (s_accept)
        begin
            if (col_inc >= len)
            begin
                column_next  = '0;
                odd_row_next = !cur_row;
            end
            else
            begin
                column_next  = col_inc[CW-1:0];
                odd_row_next = cur_row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg  <= '0;
            odd_row_reg <= 1'b0;
        end
        else
        begin
            column_reg  <= column_next;
            odd_row_reg <= odd_row_next;
        end
    end

    // input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_blue_reg    <= s_axis_tdata[PW-1:0];
            s1_green_reg   <= s_axis_tdata[2*PW-1:PW];
            s1_red_reg     <= s_axis_tdata[3*PW-1:2*PW];
            s1_col_odd_reg <= cur_col[0];
            s1_row_odd_reg <= cur_row;
            s1_idx_reg     <= cur_col[CW-1:1];
        end
    end

    // per-pixel conversion
    rgb2yuv_csc u_csc
    (
        .blue  (s1_blue_reg),
        .green (s1_green_reg),
        .red   (s1_red_reg),
        .luma  (luma),
        .u_raw (u_raw),
        .v_raw (v_raw)
    );

    // even-column chroma held for its odd neighbour
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_u_reg <= '0;
            held_v_reg <= '0;
        end
        else if (s1_adv && !s1_col_odd_reg)
        begin
            held_u_reg <= u_raw;
            held_v_reg <= v_raw;
        end
    end

    // line store: pair sums written on even rows, fetched ahead on odd rows
    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_col_odd_reg && !s1_row_odd_reg)
        begin
            store_mem[s1_idx_reg] <= {pair_v, pair_u};
        end
        if (s1_adv && !s1_col_odd_reg && s1_row_odd_reg)
        begin
            rd_data_reg <= store_mem[s1_idx_reg];
        end
    end

    // block sums and averages
    always_comb
    begin
        pair_u     = PRW'(held_u_reg) + PRW'(u_raw);
        pair_v     = PRW'(held_v_reg) + PRW'(v_raw);
        quad_u     = QW'(rd_data_reg[PRW-1:0]) + QW'(pair_u);
        quad_v     = QW'(rd_data_reg[2*PRW-1:PRW]) + QW'(pair_v);
        chroma_hit = s1_col_odd_reg && s1_row_odd_reg;
        cb         = '0;
        cr         = '0;
        if (chroma_hit)
        begin
            cb = rgb2yuv_pkg::clamp_byte(quad_u[QW-1:2], rgb2yuv_pkg::CHROMA_MIN,
                                         rgb2yuv_pkg::CHROMA_MAX);
            cr = rgb2yuv_pkg::clamp_byte(quad_v[QW-1:2], rgb2yuv_pkg::CHROMA_MIN,
                                         rgb2yuv_pkg::CHROMA_MAX);
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tvalid <= 1'b0;
        end
        else if (out_free)
        begin
            m_axis_tvalid <= s1_valid_reg;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            m_axis_tdata <= {cr, cb, luma};
            m_axis_tuser <= chroma_hit;
        end
    end

    // luma on every output beat is within the clamp range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:0] >= rgb2yuv_pkg::LUMA_MIN) &&
                          (m_axis_tdata[7:0] <= rgb2yuv_pkg::LUMA_MAX))
        else $error("luma outside clamp range");

    // a beat with block chroma carries clamped cb and cr
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (m_axis_tdata[15:8] >= rgb2yuv_pkg::CHROMA_MIN) &&
            (m_axis_tdata[15:8] <= rgb2yuv_pkg::CHROMA_MAX) &&
            (m_axis_tdata[23:16] >= rgb2yuv_pkg::CHROMA_MIN) &&
            (m_axis_tdata[23:16] <= rgb2yuv_pkg::CHROMA_MAX))
        else $error("block chroma outside clamp range");

    // a frame start restarts the position at the head of an even row
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_axis_tuser) |=>
            ((column_reg == CW'(1)) && !odd_row_reg) ||
            ((column_reg == '0) && odd_row_reg))
        else $error("position not restarted by frame start");

    // a beat without block chroma carries zero cb and cr
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[23:8] == '0))
        else $error("chroma present without a completed block");

endmodule

`default_nettype wire

// File: rtl/rgb2yuv_csc.sv
// Per-pixel colour-space conversion: clamped Y and raw U, V from one RGB pixel.
// Depends on rgb2yuv_pkg for coefficients, widths and the clamp function.
`default_nettype none

module rgb2yuv_csc
(
    input  wire rgb2yuv_pkg::pix_t blue,
    input  wire rgb2yuv_pkg::pix_t green,
    input  wire rgb2yuv_pkg::pix_t red,
    output rgb2yuv_pkg::pix_t      luma,
    output rgb2yuv_pkg::pix_t      u_raw,
    output rgb2yuv_pkg::pix_t      v_raw
);

    localparam int PW = rgb2yuv_pkg::PROD_W;
    localparam int FW = rgb2yuv_pkg::FRAC_W;

    logic [PW-1:0] y_sum;
    logic [PW-1:0] u_sum;
    logic [PW-1:0] v_sum;
    logic [PW-1:0] u_base;
    logic [PW-1:0] v_base;

    // luma: weighted sum of the three components
    assign y_sum = PW'(rgb2yuv_pkg::COEF_YR) * PW'(red)
                 + PW'(rgb2yuv_pkg::COEF_YG) * PW'(green)
                 + PW'(rgb2yuv_pkg::COEF_YB) * PW'(blue);

    // chroma: offset plus half component, minus the other two terms
    assign u_base = PW'({rgb2yuv_pkg::CHROMA_OFFSET, {FW{1'b0}}})
                  + PW'({1'b0, blue[rgb2yuv_pkg::PIX_W-1:1], {FW{1'b0}}});
    assign v_base = PW'({rgb2yuv_pkg::CHROMA_OFFSET, {FW{1'b0}}})
                  + PW'({1'b0, red[rgb2yuv_pkg::PIX_W-1:1], {FW{1'b0}}});

    assign u_sum = u_base
                 - PW'(rgb2yuv_pkg::COEF_UR) * PW'(red)
                 - PW'(rgb2yuv_pkg::COEF_UG) * PW'(green);
    assign v_sum = v_base
                 - PW'(rgb2yuv_pkg::COEF_VG) * PW'(green)
                 - PW'(rgb2yuv_pkg::COEF_VB) * PW'(blue);

    // truncate to the integer byte, clamp luma only
    assign luma  = rgb2yuv_pkg::clamp_byte(y_sum[FW+7:FW], rgb2yuv_pkg::LUMA_MIN,
                                           rgb2yuv_pkg::LUMA_MAX);
    assign u_raw = u_sum[FW+7:FW];
    assign v_raw = v_sum[FW+7:FW];

endmodule

`default_nettype wire

// File: tb/sv/tb_rgb_to_yuv420_converter.sv
// Self-checking testbench for rgb_to_yuv420_converter: luma per pixel, 2x2 chroma averages.
// A scoreboard class predicts every output beat; it depends on rgb2yuv_pkg and the RTL.
`timescale 1ns / 100ps

module tb_rgb_to_yuv420_converter;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int RANDOM_ITEMS = 520;
    localparam int DRAIN_CYCLES = 4;

    localparam int CFG_W   = rgb2yuv_pkg::CFG_W;
    localparam int PAIR_W  = rgb2yuv_pkg::PAIR_W;
    localparam int QUAD_W  = rgb2yuv_pkg::QUAD_W;
    localparam int ENTRY_W = rgb2yuv_pkg::ENTRY_W;

    // one expected output beat
    typedef struct packed {
        rgb2yuv_pkg::pix_t luma;
        logic              chroma_ok;
        rgb2yuv_pkg::pix_t cb;
        rgb2yuv_pkg::pix_t cr;
    } yuv_beat_t;

    // predicts luma and block chroma and checks them against the output stream
    class yuv420_scoreboard;
        logic [CFG_W-1:0]     width_reg;
        rgb2yuv_pkg::entry_t  pair_sums [rgb2yuv_pkg::STORE_DEPTH];
        rgb2yuv_pkg::pix_t    held_u;
        rgb2yuv_pkg::pix_t    held_v;
        rgb2yuv_pkg::col_t    col;
        bit                   odd_row;
        yuv_beat_t            awaited [$];
        int unsigned          pixels;
        int unsigned          blocks;
        int unsigned          widths_written;
        int unsigned          mismatches;

        function new();
            width_reg = CFG_W'(rgb2yuv_pkg::RESET_WIDTH);
            held_u = '0;
            held_v = '0;
            col = '0;
            odd_row = 1'b0;
            pixels = 0;
            blocks = 0;
            widths_written = 0;
            mismatches = 0;
            foreach (pair_sums[i])
            begin
                pair_sums[i] = '0;
            end
        endfunction

        // even length in use for a given register value
        function int unsigned span(input logic [CFG_W-1:0] w);
            int unsigned n;
            n = {w[CFG_W-1:1], 1'b0};
            if (n < 2)
            begin
                n = 2;
            end
            if (n > rgb2yuv_pkg::MAX_WIDTH)
            begin
                n = rgb2yuv_pkg::MAX_WIDTH;
            end
            return n;
        endfunction

        function rgb2yuv_pkg::pix_t sat(input rgb2yuv_pkg::pix_t x, input rgb2yuv_pkg::pix_t lo,
                                        input rgb2yuv_pkg::pix_t hi);
            if (x < lo)
            begin
                return lo;
            end
            if (x > hi)
            begin
                return hi;
            end
            return x;
        endfunction

        function void set_width(input logic [CFG_W-1:0] w);
            width_reg = w;
            widths_written++;
        endfunction

        // accepted input beat: advance the model and queue the output it causes
        function void note_pixel(input rgb2yuv_pkg::pix_t b, input rgb2yuv_pkg::pix_t g,
                                 input rgb2yuv_pkg::pix_t r, input logic fs);
            logic [31:0]       ri, gi, bi, ysum, usum, vsum;
            rgb2yuv_pkg::pix_t u, v;
            rgb2yuv_pkg::idx_t slot;
            logic [QUAD_W-1:0] su, sv;
            yuv_beat_t         res;
            ri = 32'(r);
            gi = 32'(g);
            bi = 32'(b);
            if (fs)
            begin
                col = '0;
                odd_row = 1'b0;
            end
            ysum = rgb2yuv_pkg::COEF_YR * ri + rgb2yuv_pkg::COEF_YG * gi
                 + rgb2yuv_pkg::COEF_YB * bi;
            usum = ((32'(rgb2yuv_pkg::CHROMA_OFFSET) + (bi >> 1)) << rgb2yuv_pkg::FRAC_W)
                 - rgb2yuv_pkg::COEF_UR * ri - rgb2yuv_pkg::COEF_UG * gi;
            vsum = ((32'(rgb2yuv_pkg::CHROMA_OFFSET) + (ri >> 1)) << rgb2yuv_pkg::FRAC_W)
                 - rgb2yuv_pkg::COEF_VG * gi - rgb2yuv_pkg::COEF_VB * bi;
            u = usum[23:16];
            v = vsum[23:16];
            res.luma = sat(ysum[23:16], rgb2yuv_pkg::LUMA_MIN, rgb2yuv_pkg::LUMA_MAX);
            res.chroma_ok = 1'b0;
            res.cb = '0;
            res.cr = '0;
            slot = rgb2yuv_pkg::idx_t'(col >> 1);
            // even column holds, odd column stores the pair or closes the block
            if (!col[0])
            begin
                held_u = u;
                held_v = v;
            end
            else if (!odd_row)
            begin
                pair_sums[slot] = {PAIR_W'(held_v) + PAIR_W'(v), PAIR_W'(held_u) + PAIR_W'(u)};
            end
            else
            begin
                su = QUAD_W'(pair_sums[slot][PAIR_W-1:0]) + QUAD_W'(held_u) + QUAD_W'(u);
                sv = QUAD_W'(pair_sums[slot][ENTRY_W-1:PAIR_W]) + QUAD_W'(held_v)
                   + QUAD_W'(v);
                res.cb = sat(su[QUAD_W-1:2], rgb2yuv_pkg::CHROMA_MIN, rgb2yuv_pkg::CHROMA_MAX);
                res.cr = sat(sv[QUAD_W-1:2], rgb2yuv_pkg::CHROMA_MIN, rgb2yuv_pkg::CHROMA_MAX);
                res.chroma_ok = 1'b1;
                blocks++;
            end
            // line wrap
            if (32'(col) + 1 >= span(width_reg))
            begin
                col = '0;
                odd_row = !odd_row;
            end
            else
            begin
                col = col + 1'b1;
            end
            awaited.push_back(res);
            pixels++;
        endfunction

        function void check_output(input rgb2yuv_pkg::pix_t luma, input logic chroma_ok,
                                   input rgb2yuv_pkg::pix_t cb, input rgb2yuv_pkg::pix_t cr);
            yuv_beat_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected output beat: luma %0d cv %0b cb %0d cr %0d",
                             luma, chroma_ok, cb, cr);
                end
                return;
            end
            want = awaited.pop_front();
            if (luma !== want.luma || chroma_ok !== want.chroma_ok || cb !== want.cb ||
                cr !== want.cr)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch at %0t: luma %0d/%0d cv %0b/%0b cb %0d/%0d cr %0d/%0d",
                             $realtime, want.luma, luma, want.chroma_ok, chroma_ok,
                             want.cb, cb, want.cr, cr);
                    $display("  (values shown as expected/actual)");
                end
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic             s_axis_tvalid = 1'b0;
    wire              s_axis_tready;
    logic [23:0]      s_axis_tdata = '0;     // blue[7:0], green[15:8], red[23:16]
    logic             s_axis_tuser = 1'b0;   // frame_start
    wire              m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    wire  [23:0]      m_axis_tdata;          // luma[7:0], cb[15:8], cr[23:16]
    wire              m_axis_tuser;          // chroma_valid

    yuv420_scoreboard sb;
    bit               steady = 1'b0;
    bit               restart_due = 1'b0;
    int               rx_hold = 0;
    int               cycle_count = 0;

    rgb_to_yuv420_converter u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timed out with %0d beats outstanding", sb.awaited.size());
            $display("FAILURE");
            $finish;
        end
    end

    // output side: check each beat, then stall for a random number of cycles unless steady
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_output(m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[15:8],
                            m_axis_tdata[23:16]);
            rx_hold = steady ? 0 : $urandom_range(0, 5);
        end
        else if (rx_hold > 0)
        begin
            rx_hold = rx_hold - 1;
        end
        m_axis_tready <= (rx_hold == 0);
    end

    // mostly random bytes, with the extremes often
    function automatic rgb2yuv_pkg::pix_t pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return rgb2yuv_pkg::pix_t'($urandom_range(0, 255));
        endcase
    endfunction

    // one input beat after a random gap unless steady
    task automatic send_pixel(input rgb2yuv_pkg::pix_t b, input rgb2yuv_pkg::pix_t g,
                              input rgb2yuv_pkg::pix_t r, input logic fs);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {r, g, b};
        s_axis_tuser <= fs;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_pixel(b, g, r, fs);
    endtask

    // stop sending and let every queued beat come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // a wider line could read store entries never written, so restart the frame then
    task automatic set_width(input logic [CFG_W-1:0] w);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= w;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (sb.span(w) > sb.span(sb.width_reg))
        begin
            restart_due = 1'b1;
        end
        sb.set_width(w);
    endtask

    task automatic run_pixels(input int n);
        logic fs;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 49) == 0)
            begin
                steady = !steady;
            end
            fs = restart_due || ($urandom_range(0, 99) == 0);
            restart_due = 1'b0;
            send_pixel(pick_byte(), pick_byte(), pick_byte(), fs);
        end
    endtask

    // flat colour blocks at the extremes, stored as {red, green, blue}
    logic [23:0] swatch [6] = '{24'h000000, 24'hFFFFFF, 24'h0000FF,
                                24'hFFFF00, 24'hFF0000, 24'h00FFFF};

    initial
    begin
        int               random_count;
        int               n;
        logic [CFG_W-1:0] w;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset width, with one full pause of the sender halfway
        restart_due = 1'b1;
        run_pixels(60);
        wait_drained();
        run_pixels(60);

        // two-pixel lines: each four beats make one block, clamps at both ends
        set_width(12'd2);
        for (int k = 0; k < 6; k++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                send_pixel(swatch[k][7:0], swatch[k][15:8], swatch[k][23:16],
                           k == 0 && j == 0);
            end
        end

        // widths below the minimum and odd widths
        set_width(12'd0);
        run_pixels(20);
        set_width(12'd1);
        run_pixels(20);
        set_width(12'd7);
        run_pixels(60);

        // out-of-range width held at the maximum, then a narrower width mid-line
        set_width(12'hFFF);
        run_pixels(100);
        set_width(12'd4);
        run_pixels(60);

        // random widths, mostly narrow
        random_count = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                w = CFG_W'($urandom_range(0, 4095));
            end
            else
            begin
                w = CFG_W'($urandom_range(0, 72));
            end
            set_width(w);
            n = $urandom_range(20, 140);
            if ($urandom_range(0, 2) == 0)
            begin
                run_pixels(n / 2);
                wait_drained();
                run_pixels(n - n / 2);
            end
            else
            begin
                run_pixels(n);
            end
            random_count += n;
        end

        wait_drained();
        $display("run covered %0d pixels and %0d completed 2x2 chroma blocks",
                 sb.pixels, sb.blocks);
        $display("over %0d width settings, %0d mismatching beats", sb.widths_written,
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
